### design/lrq_pkg.sv
// Package for the line assembling receive queue: command codes, state codes,
// character constants and default sizes. Depends on nothing.

package lrq_pkg;

   localparam int LINES_DEF    = 16;
   localparam int LINE_LEN_DEF = 64;

   localparam int CMD_W   = 2;
   localparam int BYTE_W  = 8;
   localparam int INDEX_W = 6;
   localparam int LEN_W   = 6;
   localparam int COUNT_W = 4;

   localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;

   typedef enum logic [CMD_W-1:0] {
      CMD_BYTE = 2'd0,
      CMD_READ = 2'd1,
      CMD_POP  = 2'd2,
      CMD_NOP  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

endpackage

### design/line_assembling_rx_queue.sv
// Line assembling receive queue: builds text lines from received bytes in a ring of
// line slots held in two synchronous memories. Depends on lrq_pkg.
// The result is on the rsp_ ports, with rsp_valid high, in the cycle after the
// accepting edge; busy is high then, so no new beat is taken in that cycle. The memories are
// read at the accepting edge and written back in the following cycle. The receiver cannot
// stall. Reset clears the slot pointers and the character position, not the memories.

module line_assembling_rx_queue #(
   parameter int LINES    = lrq_pkg::LINES_DEF,
   parameter int LINE_LEN = lrq_pkg::LINE_LEN_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [lrq_pkg::CMD_W-1:0]     req_command,
   input  logic [lrq_pkg::BYTE_W-1:0]    req_rx_byte,
   input  logic [lrq_pkg::INDEX_W-1:0]   req_char_index,
   output logic                          rsp_valid,
   output logic [lrq_pkg::BYTE_W-1:0]    rsp_read_char,
   output logic [lrq_pkg::LEN_W-1:0]     rsp_line_length,
   output logic                          rsp_queue_empty,
   output logic [lrq_pkg::COUNT_W-1:0]   rsp_lines_waiting,
   output logic                          rsp_byte_dropped
);

   localparam int SW    = $clog2(LINES);
   localparam int PW    = $clog2(LINE_LEN);
   localparam int CW    = (PW > lrq_pkg::INDEX_W) ? PW : lrq_pkg::INDEX_W;
   localparam int LW    = (PW > lrq_pkg::LEN_W) ? PW : lrq_pkg::LEN_W;
   localparam int NW    = ((SW + 1) > lrq_pkg::COUNT_W) ? (SW + 1) : lrq_pkg::COUNT_W;
   localparam int DEPTH = LINES * (2 ** PW);

   logic [lrq_pkg::BYTE_W-1:0] line_mem [DEPTH];
   logic [PW-1:0]              len_mem  [LINES];

   lrq_pkg::state_type state_ff, state_in;
   logic [SW-1:0] write_slot_ff, write_slot_in;
   logic [SW-1:0] read_slot_ff, read_slot_in;
   logic [PW-1:0] char_pos_ff, char_pos_in;

   lrq_pkg::cmd_type            cmd_ff;
   logic [lrq_pkg::BYTE_W-1:0]  byte_ff;
   logic [lrq_pkg::INDEX_W-1:0] index_ff;

   logic [lrq_pkg::BYTE_W-1:0] char_rd_ff;
   logic [PW-1:0]              len_front_rd_ff;
   logic [PW-1:0]              len_next_rd_ff;

   logic          accept;
   logic          exec;
   logic          empty_now, full_now, is_term;
   logic          line_we, len_we, dropped;
   logic [CW-1:0] index_wide, len_wide;
   logic [PW-1:0] front_len;
   logic [LW-1:0] front_len_wide;
   logic [NW-1:0] count;
   logic [lrq_pkg::BYTE_W-1:0] read_char;
   logic [PW-1:0] rd_index;

   function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
      if (s == SW'(LINES - 1)) begin
         return '0;
      end
      return s + SW'(1);
   endfunction

   assign accept    = start && (state_ff == lrq_pkg::ST_IDLE);
   assign exec      = (state_ff == lrq_pkg::ST_EXEC);
   assign busy      = exec;
   assign rd_index  = PW'(CW'(req_char_index));

   // Both possible front lengths are fetched so that a pop needs no second read.
   always_ff @(posedge clock) begin
      char_rd_ff      <= line_mem[{read_slot_ff, rd_index}];
      len_front_rd_ff <= len_mem[read_slot_ff];
      len_next_rd_ff  <= len_mem[next_slot(read_slot_ff)];
      if (line_we) begin
         line_mem[{write_slot_ff, char_pos_ff}] <= byte_ff;
      end
      if (len_we) begin
         len_mem[write_slot_ff] <= char_pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= lrq_pkg::cmd_type'(req_command);
         byte_ff  <= req_rx_byte;
         index_ff <= req_char_index;
      end
   end

   assign empty_now  = (write_slot_ff == read_slot_ff);
   assign full_now   = (next_slot(write_slot_ff) == read_slot_ff);
   assign is_term    = (byte_ff == lrq_pkg::CH_LF) || (byte_ff == lrq_pkg::CH_CR);
   assign index_wide = CW'(index_ff);
   assign len_wide   = CW'(len_front_rd_ff);

   always_comb begin
      state_in      = state_ff;
      write_slot_in = write_slot_ff;
      read_slot_in  = read_slot_ff;
      char_pos_in   = char_pos_ff;
      line_we       = 1'b0;
      len_we        = 1'b0;
      dropped       = 1'b0;
      read_char     = '0;
      front_len     = len_front_rd_ff;
      case (state_ff)
         lrq_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = lrq_pkg::ST_EXEC;
            end
         end
         lrq_pkg::ST_EXEC: begin
            state_in = lrq_pkg::ST_IDLE;
            case (cmd_ff)
               lrq_pkg::CMD_BYTE: begin
                  if (full_now) begin
                     dropped = 1'b1;
                  end else if (is_term) begin
                     len_we        = 1'b1;
                     char_pos_in   = '0;
                     write_slot_in = next_slot(write_slot_ff);
                     // A line closed into an empty queue becomes the front line at once.
                     if (empty_now) begin
                        front_len = char_pos_ff;
                     end
                  end else if (CW'(char_pos_ff) < CW'(LINE_LEN - 1)) begin
                     line_we     = 1'b1;
                     char_pos_in = char_pos_ff + PW'(1);
                  end
               end
               lrq_pkg::CMD_READ: begin
                  if (!empty_now && (index_wide < len_wide)
                      && ((CW + 1)'(index_ff) < (CW + 1)'(LINE_LEN))) begin
                     read_char = char_rd_ff;
                  end
               end
               lrq_pkg::CMD_POP: begin
                  if (!empty_now) begin
                     read_slot_in = next_slot(read_slot_ff);
                     front_len    = len_next_rd_ff;
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
            state_in = lrq_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (write_slot_in >= read_slot_in) begin
         count = NW'(write_slot_in) - NW'(read_slot_in);
      end else begin
         count = NW'(write_slot_in) + NW'(LINES) - NW'(read_slot_in);
      end
   end

   assign front_len_wide    = LW'(front_len);
   assign rsp_valid         = exec;
   assign rsp_read_char     = read_char;
   assign rsp_queue_empty   = (write_slot_in == read_slot_in);
   assign rsp_line_length   = rsp_queue_empty ? '0 : front_len_wide[lrq_pkg::LEN_W-1:0];
   assign rsp_lines_waiting = count[lrq_pkg::COUNT_W-1:0];
   assign rsp_byte_dropped  = dropped;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lrq_pkg::ST_IDLE;
         write_slot_ff <= '0;
         read_slot_ff  <= '0;
         char_pos_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         write_slot_ff <= write_slot_in;
         read_slot_ff  <= read_slot_in;
         char_pos_ff   <= char_pos_in;
      end
   end

endmodule
